// ===== rtl/nal_unit_start_code_indexer_core_macros.svh =====
// Assertion macros for the start code indexer RTL.
// Included by files that carry concurrent checks; no other dependencies.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef NAL_UNIT_START_CODE_INDEXER_CORE_MACROS_SVH
`define NAL_UNIT_START_CODE_INDEXER_CORE_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define NSCI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsci assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NSCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsci assertion failed");

`else

`define NSCI_ASSERT_SAME(label, ante, cons)
`define NSCI_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/nsci_pkg.sv =====
// Shared types and constants for the Annex B start code indexer.
// No dependencies; used by the interfaces and the top level.
package nsci_pkg;

    localparam int DEFAULT_LENGTH_WIDTH = 24;
    localparam int DEFAULT_OFFSET_WIDTH = 32;

    // Fixed widths of the descriptor fields
    localparam int UNIT_OFFSET_W = 32;
    localparam int UNIT_LENGTH_W = 24;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_CODEC_SELECT        = 1'b0,
        REG_PARAMETER_SETS_ONLY = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        CODEC_H264 = 1'b0,
        CODEC_H265 = 1'b1
    } codec_t;

    localparam logic [2:0] SC_LEN_SHORT = 3'd3;
    localparam logic [2:0] SC_LEN_LONG  = 3'd4;

    localparam logic [1:0] ZERO_RUN_MAX = 2'd3;
    localparam logic [1:0] ZERO_RUN_CODE = 2'd2;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    localparam logic [5:0] H264_TYPE_SPS = 6'd7;
    localparam logic [5:0] H264_TYPE_PPS = 6'd8;
    localparam logic [5:0] H265_TYPE_VPS = 6'd32;
    localparam logic [5:0] H265_TYPE_PPS = 6'd34;

    localparam logic [1:0] HDR_POS_NONE  = 2'd0;
    localparam logic [1:0] HDR_POS_FIRST = 2'd1;
    localparam logic [1:0] HDR_POS_BOTH  = 2'd2;

endpackage

// ===== rtl/nsci_ifs.sv =====
// Valid/ready channel interfaces for the start code indexer.
// Depends on nsci_pkg for the descriptor field widths.
interface nsci_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface nsci_desc_if;
    logic                               valid;
    logic                               ready;
    logic [nsci_pkg::UNIT_OFFSET_W-1:0] unit_offset;
    logic [nsci_pkg::UNIT_LENGTH_W-1:0] unit_length;
    logic                               length_saturated;
    logic [2:0]                         start_code_length;
    logic [5:0]                         unit_type;
    logic [5:0]                         priority_or_layer;
    logic [2:0]                         temporal_id;
    logic                               is_parameter_set;

    modport source (
        output valid, output unit_offset, output unit_length, output length_saturated,
        output start_code_length, output unit_type, output priority_or_layer,
        output temporal_id, output is_parameter_set, input ready
    );
    modport sink (
        input valid, input unit_offset, input unit_length, input length_saturated,
        input start_code_length, input unit_type, input priority_or_layer,
        input temporal_id, input is_parameter_set, output ready
    );
endinterface

// ===== rtl/nal_unit_start_code_indexer_core.sv =====
// Top level of the Annex B start code indexer: byte input, descriptor output, APB registers.
// Depends on nsci_pkg, nsci_ifs.sv and nal_unit_start_code_indexer_core_macros.svh.
//
//   port     | direction | carries
//   ---------+-----------+-------------------------------------------------
//   stream   | sink      | one stream byte and a restart flag per request
//   desc     | source    | one descriptor per closed, unfiltered unit
//   apb      | slave     | codec_select at 0x0, parameter_sets_only at 0x4
//
// One byte per cycle sustained. A byte is captured in the input register; when it advances,
// the scanner state and the descriptor register update together: the request that closes a
// unit passes the input register, then its descriptor is loaded into the descriptor register.
// Reset clears the scanner state, the stream offset and both valid flags; no clearing pass.
// A descriptor held by desc.ready low stalls a full input register, and stream.ready drops.
`include "nal_unit_start_code_indexer_core_macros.svh"

module nal_unit_start_code_indexer_core #(
    parameter int LENGTH_WIDTH = nsci_pkg::DEFAULT_LENGTH_WIDTH,
    parameter int OFFSET_WIDTH = nsci_pkg::DEFAULT_OFFSET_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    nsci_byte_if.sink                       stream,
    nsci_desc_if.source                     desc,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nsci_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nsci_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nsci_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import nsci_pkg::*;

    localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = {LENGTH_WIDTH{1'b1}};

    // Configuration registers
    logic     codec_select_reg;
    logic     ps_only_reg;
    cfg_reg_t cfg_index;
    logic     cfg_write;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;

    // Scanner state
    logic [1:0]              zero_run_reg,     zero_run_next;
    logic                    inside_reg,       inside_next;
    logic [OFFSET_WIDTH-1:0] start_offset_reg, start_offset_next;
    logic [LENGTH_WIDTH-1:0] length_reg,       length_next;
    logic [2:0]              code_len_reg,     code_len_next;
    logic                    saturated_reg,    saturated_next;
    logic [1:0]              hdr_pos_reg,      hdr_pos_next;
    logic [15:0]             hdr_bytes_reg,    hdr_bytes_next;
    logic [OFFSET_WIDTH-1:0] stream_offset_reg;

    // Descriptor register
    logic                     out_valid_reg, out_valid_next;
    logic [UNIT_OFFSET_W-1:0] out_offset_reg;
    logic [UNIT_LENGTH_W-1:0] out_length_reg;
    logic                     out_saturated_reg;
    logic [2:0]               out_code_len_reg;
    logic [5:0]               out_type_reg;
    logic [5:0]               out_prio_reg;
    logic [2:0]               out_tid_reg;
    logic                     out_ps_reg;

    // Working signals
    logic                    out_free;
    logic                    advance;
    logic [1:0]              zr_eff;
    logic                    inside_eff;
    logic [LENGTH_WIDTH-1:0] length_eff;
    logic                    saturated_eff;
    logic [1:0]              hdr_pos_eff;
    logic [15:0]             hdr_bytes_eff;
    logic                    is_start;
    logic [2:0]              code_len;
    logic                    do_grow;
    logic [2:0]              grow_amt;
    logic [LENGTH_WIDTH:0]   grow_sum;
    logic [LENGTH_WIDTH-1:0] grown_length;
    logic                    grown_sat;
    logic [7:0]              hb0;
    logic [7:0]              hb1;
    logic [5:0]              dec_type;
    logic [5:0]              dec_prio;
    logic [2:0]              dec_tid;
    logic                    dec_ps;
    logic                    emit;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_index = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_index)
            REG_CODEC_SELECT:        prdata = {{(APB_DATA_W-1){1'b0}}, codec_select_reg};
            REG_PARAMETER_SETS_ONLY: prdata = {{(APB_DATA_W-1){1'b0}}, ps_only_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_select_reg <= 1'b0;
            ps_only_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CODEC_SELECT:        codec_select_reg <= pwdata[0];
                REG_PARAMETER_SETS_ONLY: ps_only_reg      <= pwdata[0];
                default:                 ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_free     = !out_valid_reg || desc.ready;
    assign advance      = in_valid_reg && out_free;
    assign stream.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (stream.ready)
            in_valid_reg <= stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_byte_reg    <= stream.data_byte;
            in_restart_reg <= stream.restart;
        end
    end

    // ---------------- scanner ----------------
    // Restart drops the unit in progress before the byte is looked at
    always_comb
    begin
        zr_eff        = in_restart_reg ? 2'd0 : zero_run_reg;
        inside_eff    = in_restart_reg ? 1'b0 : inside_reg;
        length_eff    = in_restart_reg ? '0 : length_reg;
        saturated_eff = in_restart_reg ? 1'b0 : saturated_reg;
        hdr_pos_eff   = in_restart_reg ? HDR_POS_NONE : hdr_pos_reg;
        hdr_bytes_eff = in_restart_reg ? 16'h0000 : hdr_bytes_reg;
    end

    assign is_start = (in_byte_reg == BYTE_ONE) && (zr_eff >= ZERO_RUN_CODE);
    assign code_len = (zr_eff == ZERO_RUN_MAX) ? SC_LEN_LONG : SC_LEN_SHORT;

    // Header decode of the unit being closed
    assign hb0 = hdr_bytes_eff[15:8];
    assign hb1 = hdr_bytes_eff[7:0];

    always_comb
    begin
        unique case (codec_t'(codec_select_reg))
            CODEC_H265:
            begin
                dec_type = hb0[6:1];
                dec_prio = {hb0[0], hb1[7:3]};
                dec_tid  = hb1[2:0];
                dec_ps   = (dec_type >= H265_TYPE_VPS) && (dec_type <= H265_TYPE_PPS);
            end
            default:
            begin
                dec_type = {1'b0, hb0[4:0]};
                dec_prio = {4'b0000, hb0[6:5]};
                dec_tid  = 3'd0;
                dec_ps   = (dec_type == H264_TYPE_SPS) || (dec_type == H264_TYPE_PPS);
            end
        endcase
    end

    assign emit = is_start && inside_eff && !(ps_only_reg && !dec_ps);

    // Zeros stay pending until a nonzero byte, or the oldest one falls out of a full run
    always_comb
    begin
        do_grow  = 1'b0;
        grow_amt = 3'd1;
        if (!is_start && inside_eff)
        begin
            if (in_byte_reg != BYTE_ZERO)
            begin
                do_grow  = 1'b1;
                grow_amt = 3'({1'b0, zr_eff} + 3'd1);
            end
            else if (zr_eff == ZERO_RUN_MAX)
            begin
                do_grow = 1'b1;
            end
        end
    end

    assign grow_sum     = {1'b0, length_eff} + (LENGTH_WIDTH+1)'(grow_amt);
    assign grown_length = grow_sum[LENGTH_WIDTH] ? LENGTH_MAX : grow_sum[LENGTH_WIDTH-1:0];
    assign grown_sat    = saturated_eff || grow_sum[LENGTH_WIDTH];

    always_comb
    begin
        zero_run_next     = zr_eff;
        inside_next       = inside_eff;
        start_offset_next = start_offset_reg;
        length_next       = length_eff;
        code_len_next     = in_restart_reg ? 3'd0 : code_len_reg;
        saturated_next    = saturated_eff;
        hdr_pos_next      = hdr_pos_eff;
        hdr_bytes_next    = hdr_bytes_eff;

        if (is_start)
        begin
            // Open a new unit; the start code always fits the counter
            inside_next       = 1'b1;
            start_offset_next = stream_offset_reg - OFFSET_WIDTH'(code_len) + OFFSET_WIDTH'(1);
            length_next       = LENGTH_WIDTH'(code_len);
            saturated_next    = 1'b0;
            code_len_next     = code_len;
            hdr_pos_next      = HDR_POS_NONE;
            hdr_bytes_next    = 16'h0000;
            zero_run_next     = 2'd0;
        end
        else
        begin
            if (inside_eff)
            begin
                priority if (hdr_pos_eff == HDR_POS_NONE)
                begin
                    hdr_bytes_next[15:8] = in_byte_reg;
                    hdr_pos_next         = HDR_POS_FIRST;
                end
                else if (hdr_pos_eff == HDR_POS_FIRST)
                begin
                    hdr_bytes_next[7:0] = in_byte_reg;
                    hdr_pos_next        = HDR_POS_BOTH;
                end
                else
                begin
                    // both header bytes captured: hold them
                    hdr_pos_next = hdr_pos_eff;
                end
            end
            if (do_grow)
            begin
                length_next    = grown_length;
                saturated_next = grown_sat;
            end
            if (in_byte_reg != BYTE_ZERO)
                zero_run_next = 2'd0;
            else if (zr_eff != ZERO_RUN_MAX)
                zero_run_next = zr_eff + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg      <= 2'd0;
            inside_reg        <= 1'b0;
            start_offset_reg  <= '0;
            length_reg        <= '0;
            code_len_reg      <= 3'd0;
            saturated_reg     <= 1'b0;
            hdr_pos_reg       <= HDR_POS_NONE;
            hdr_bytes_reg     <= 16'h0000;
            stream_offset_reg <= '0;
        end
        else if (advance)
        begin
            zero_run_reg      <= zero_run_next;
            inside_reg        <= inside_next;
            start_offset_reg  <= start_offset_next;
            length_reg        <= length_next;
            code_len_reg      <= code_len_next;
            saturated_reg     <= saturated_next;
            hdr_pos_reg       <= hdr_pos_next;
            hdr_bytes_reg     <= hdr_bytes_next;
            stream_offset_reg <= stream_offset_reg + OFFSET_WIDTH'(1);
        end
    end

    // ---------------- descriptor register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && emit)
            out_valid_next = 1'b1;
        else if (desc.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_offset_reg    <= UNIT_OFFSET_W'(start_offset_reg);
            out_length_reg    <= UNIT_LENGTH_W'(length_eff);
            out_saturated_reg <= saturated_eff;
            out_code_len_reg  <= code_len_reg;
            out_type_reg      <= dec_type;
            out_prio_reg      <= dec_prio;
            out_tid_reg       <= dec_tid;
            out_ps_reg        <= dec_ps;
        end
    end

    assign desc.valid             = out_valid_reg;
    assign desc.unit_offset       = out_offset_reg;
    assign desc.unit_length       = out_length_reg;
    assign desc.length_saturated  = out_saturated_reg;
    assign desc.start_code_length = out_code_len_reg;
    assign desc.unit_type         = out_type_reg;
    assign desc.priority_or_layer = out_prio_reg;
    assign desc.temporal_id       = out_tid_reg;
    assign desc.is_parameter_set  = out_ps_reg;

    // ---------------- checks ----------------
    `NSCI_ASSERT_SAME(a_idle_no_length, !inside_reg, length_reg == '0)
    `NSCI_ASSERT_SAME(a_code_len_legal, inside_reg,
        code_len_reg == SC_LEN_SHORT || code_len_reg == SC_LEN_LONG)
    `NSCI_ASSERT_SAME(a_length_covers_code, inside_reg, length_reg >= LENGTH_WIDTH'(SC_LEN_SHORT))
    `NSCI_ASSERT_SAME(a_sat_at_max, saturated_reg, length_reg == LENGTH_MAX)
    `NSCI_ASSERT_NEXT(a_emit_sets_valid, advance && emit, out_valid_reg)

endmodule

// ===== sim/nal_unit_tracker.sv =====
// Watches the byte, descriptor and APB ports of the start code indexer.
// Tracks units, predicts each descriptor and compares it; depends on nsci_pkg and nsci_ifs.sv.
module nal_unit_tracker
    import nsci_pkg::*;
#(
    parameter int LEN_W = DEFAULT_LENGTH_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    nsci_byte_if                  stream,
    nsci_desc_if                  desc,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    fail_count,
    output int                    outstanding,
    output int                    bytes_seen,
    output int                    units_checked,
    output int                    units_clamped,
    output int                    units_filtered
);

    localparam logic [LEN_W-1:0] LEN_LIMIT = '1;

    typedef struct {
        logic [UNIT_OFFSET_W-1:0] unit_offset;
        logic [UNIT_LENGTH_W-1:0] unit_length;
        logic                     saturated;
        logic [2:0]               code_length;
        logic [5:0]               unit_type;
        logic [5:0]               prio_layer;
        logic [2:0]               temporal_id;
        logic                     param_set;
    } nal_desc_t;

    nal_desc_t pending_units[$];

    codec_t           codec;
    logic             ps_only;
    logic [1:0]       zero_run;
    logic             in_unit;
    logic [31:0]      unit_start;
    logic [LEN_W-1:0] unit_len;
    logic [2:0]       code_len;
    logic             clamped;
    logic [1:0]       hdr_pos;
    logic [15:0]      hdr;
    logic [31:0]      byte_pos;

    task automatic clear_unit();
        zero_run   = '0;
        in_unit    = 1'b0;
        unit_start = '0;
        unit_len   = '0;
        code_len   = '0;
        clamped    = 1'b0;
        hdr_pos    = HDR_POS_NONE;
        hdr        = '0;
    endtask

    task automatic extend_unit(input logic [2:0] n);
        logic [LEN_W:0] sum;
        sum = {1'b0, unit_len} + (LEN_W + 1)'(n);
        if (sum > {1'b0, LEN_LIMIT}) begin
            unit_len = LEN_LIMIT;
            clamped  = 1'b1;
        end else begin
            unit_len = sum[LEN_W-1:0];
        end
    endtask

    task automatic close_unit();
        nal_desc_t  d;
        logic [7:0] b0;
        logic [7:0] b1;
        b0 = hdr[15:8];
        b1 = hdr[7:0];
        if (codec == CODEC_H265) begin
            d.unit_type   = b0[6:1];
            d.prio_layer  = {b0[0], b1[7:3]};
            d.temporal_id = b1[2:0];
            d.param_set   = (d.unit_type >= H265_TYPE_VPS) && (d.unit_type <= H265_TYPE_PPS);
        end else begin
            d.unit_type   = {1'b0, b0[4:0]};
            d.prio_layer  = {4'd0, b0[6:5]};
            d.temporal_id = 3'd0;
            d.param_set   = (d.unit_type == H264_TYPE_SPS) || (d.unit_type == H264_TYPE_PPS);
        end
        if (ps_only && !d.param_set) begin
            units_filtered++;
        end else begin
            d.unit_offset = unit_start;
            d.unit_length = UNIT_LENGTH_W'(unit_len);
            d.saturated   = clamped;
            d.code_length = code_len;
            pending_units.push_back(d);
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input logic restart);
        logic [31:0] here;
        logic [2:0]  clen;
        here = byte_pos;
        if (restart)
            clear_unit();
        byte_pos = byte_pos + 32'd1;
        if (b == BYTE_ONE && zero_run >= ZERO_RUN_CODE) begin
            clen = (zero_run == ZERO_RUN_MAX) ? SC_LEN_LONG : SC_LEN_SHORT;
            if (in_unit)
                close_unit();
            in_unit    = 1'b1;
            unit_start = here - 32'(clen - 3'd1);
            unit_len   = '0;
            clamped    = 1'b0;
            extend_unit(clen);
            code_len   = clen;
            hdr_pos    = HDR_POS_NONE;
            hdr        = '0;
            zero_run   = '0;
        end else begin
            // header bytes are taken even when they are zeros of the next code
            if (in_unit) begin
                if (hdr_pos == HDR_POS_NONE) begin
                    hdr[15:8] = b;
                    hdr_pos   = HDR_POS_FIRST;
                end else if (hdr_pos == HDR_POS_FIRST) begin
                    hdr[7:0] = b;
                    hdr_pos  = HDR_POS_BOTH;
                end
            end
            if (b == BYTE_ZERO) begin
                // zeros beyond three belong to the open unit
                if (zero_run == ZERO_RUN_MAX) begin
                    if (in_unit)
                        extend_unit(3'd1);
                end else begin
                    zero_run = zero_run + 2'd1;
                end
            end else begin
                if (in_unit)
                    extend_unit({1'b0, zero_run} + 3'd1);
                zero_run = '0;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        nal_desc_t want;
        if (!rst_n) begin
            pending_units.delete();
            codec          = CODEC_H264;
            ps_only        = 1'b0;
            byte_pos       = '0;
            clear_unit();
            fail_count     = 0;
            outstanding    = 0;
            bytes_seen     = 0;
            units_checked  = 0;
            units_clamped  = 0;
            units_filtered = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (cfg_reg_t'(paddr[2]))
                    REG_CODEC_SELECT:        codec = codec_t'(pwdata[0]);
                    REG_PARAMETER_SETS_ONLY: ps_only = pwdata[0];
                    default: ;
                endcase
            end
            // check before predicting: a descriptor never leaves in the cycle its byte enters
            if (desc.valid && desc.ready) begin
                if (pending_units.size() == 0) begin
                    $error("descriptor at offset %0d arrived with none expected", desc.unit_offset);
                    fail_count++;
                end else begin
                    want = pending_units.pop_front();
                    check_field("unit_offset", want.unit_offset, desc.unit_offset);
                    check_field("unit_length", 32'(want.unit_length), 32'(desc.unit_length));
                    check_field("length_saturated", 32'(want.saturated),
                                32'(desc.length_saturated));
                    check_field("start_code_length", 32'(want.code_length),
                                32'(desc.start_code_length));
                    check_field("unit_type", 32'(want.unit_type), 32'(desc.unit_type));
                    check_field("priority_or_layer", 32'(want.prio_layer),
                                32'(desc.priority_or_layer));
                    check_field("temporal_id", 32'(want.temporal_id), 32'(desc.temporal_id));
                    check_field("is_parameter_set", 32'(want.param_set),
                                32'(desc.is_parameter_set));
                    units_checked++;
                    if (want.saturated)
                        units_clamped++;
                end
            end
            if (stream.valid && stream.ready) begin
                take_byte(stream.data_byte, stream.restart);
                bytes_seen++;
            end
            outstanding = pending_units.size();
        end
    end

endmodule

// ===== sim/nal_unit_start_code_indexer_core_tb.sv =====
// Stimulus and verdict for the Annex B start code indexer.
// Drives bytes, descriptor backpressure and APB writes; nal_unit_tracker does the checking.
// Depends on nsci_pkg, nsci_ifs.sv, the RTL top level and nal_unit_tracker.sv.
module nal_unit_start_code_indexer_core_tb;
    import nsci_pkg::*;

    localparam int LEN_W        = DEFAULT_LENGTH_WIDTH;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 700;
    localparam logic [8:0] RS   = 9'h100;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int outstanding;
    int bytes_seen;
    int units_checked;
    int units_clamped;
    int units_filtered;

    int items_sent;
    int burst_left;
    int stall_left;
    int idle_cycles;
    logic [15:0] stall_mask;
    logic [8:0]  opening[$];

    nsci_byte_if stream();
    nsci_desc_if desc();

    nal_unit_start_code_indexer_core #(
        .LENGTH_WIDTH(LEN_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .desc   (desc),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    nal_unit_tracker #(
        .LEN_W(LEN_W)
    ) unit_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .stream        (stream),
        .desc          (desc),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .bytes_seen    (bytes_seen),
        .units_checked (units_checked),
        .units_clamped (units_clamped),
        .units_filtered(units_filtered)
    );

    always #1 clk = ~clk;

    function automatic logic rare_restart();
        return $urandom_range(0, 63) == 0;
    endfunction

    // one request per call; called and returns at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic restart);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                stream.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        stream.valid     <= 1'b1;
        stream.data_byte <= b;
        stream.restart   <= restart;
        @(posedge clk);
        while (!stream.ready)
            @(posedge clk);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // hold the sender until every descriptor is out and the pipeline is empty
    task automatic settle();
        stream.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= APB_DATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_units(input int n_items, input codec_t codec, input bit hold_midway);
        int         stop_at;
        int         zeros;
        int         body;
        bit         held;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] nb;
        stop_at = items_sent + n_items;
        held    = 1'b0;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
                zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 6) : $urandom_range(2, 3);
                repeat (zeros) push_byte(BYTE_ZERO, rare_restart());
                push_byte(BYTE_ONE, rare_restart());
                b0 = 8'($urandom);
                b1 = 8'($urandom);
                // bias toward parameter sets so the filter passes some units
                if ($urandom_range(0, 1) == 1) begin
                    if (codec == CODEC_H265)
                        b0[6:1] = 6'($urandom_range(31, 35));
                    else
                        b0[4:0] = ($urandom_range(0, 1) == 1) ? 5'd7 : 5'd8;
                end
                body = $urandom_range(0, 12);
                if (body > 0)
                    push_byte(b0, 1'b0);
                if (body > 1)
                    push_byte(b1, 1'b0);
                for (int i = 2; i < body; i++)
                    push_byte(($urandom_range(0, 3) == 0) ? BYTE_ZERO : 8'($urandom),
                              rare_restart());
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 3))
                        0, 1:    nb = BYTE_ZERO;
                        2:       nb = BYTE_ONE;
                        default: nb = 8'($urandom);
                    endcase
                    push_byte(nb, $urandom_range(0, 4) == 0);
                end
            end
            if (hold_midway && !held && items_sent >= stop_at - n_items / 2) begin
                settle();
                held = 1'b1;
            end
        end
    endtask

    // descriptor receiver: stall on a random mask, redrawn whenever stall_left runs out
    initial begin
        desc.ready = 1'b0;
        stall_left = 0;
        stall_mask = '1;
        forever begin
            @(negedge clk);
            if (stall_left == 0) begin
                stall_left = 64;
                stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
            end
            stall_left--;
            desc.ready <= stall_mask[stall_left[3:0]];
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((stream.valid && stream.ready) || (desc.valid && desc.ready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL nal_unit_start_code_indexer_core");
        $finish;
    end

    initial begin
        stream.valid     = 1'b0;
        stream.data_byte = '0;
        stream.restart   = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        items_sent       = 0;
        burst_left       = 0;
        opening = '{
            9'h0FF, 9'h000, 9'h001,                          // lone zero before 01: no code
            9'h000, 9'h000, 9'h001, 9'h067, 9'h0AA,          // short code, SPS header
            9'h000, 9'h000, 9'h000, 9'h001, 9'h068,          // long code closes it
            9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h001,  // extra zeros stay behind
            9'h000, 9'h000, 9'h001,                          // empty unit, header from zeros
            9'h0E5, 9'h000, 9'h000, 9'h001,                  // one header byte only
            9'h01F, RS | 9'h033, 9'h000, 9'h000, RS | 9'h001, // restart drops unit and zeros
            9'h000, 9'h000, 9'h001, 9'h080, 9'h000, 9'h000, 9'h001
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening[i])
            push_byte(opening[i][7:0], opening[i][8]);

        settle();
        write_reg(REG_CODEC_SELECT, 1'b1);
        random_units(RANDOM_ITEMS / 4, CODEC_H265, 1'b1);
        settle();
        write_reg(REG_PARAMETER_SETS_ONLY, 1'b1);
        random_units(RANDOM_ITEMS / 4, CODEC_H265, 1'b0);
        settle();
        write_reg(REG_CODEC_SELECT, 1'b0);
        random_units(RANDOM_ITEMS / 4, CODEC_H264, 1'b0);
        settle();
        write_reg(REG_PARAMETER_SETS_ONLY, 1'b0);
        random_units(RANDOM_ITEMS / 4, CODEC_H264, 1'b0);
        settle();

        $display("Run covered %0d stream bytes under both codecs with and without filtering:",
                 bytes_seen);
        $display("%0d descriptors checked, %0d of them clamped, %0d units filtered out",
                 units_checked, units_clamped, units_filtered);
        if (fail_count == 0)
            $display("PASS nal_unit_start_code_indexer_core");
        else
            $display("FAIL nal_unit_start_code_indexer_core");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/nsci_pkg.sv
rtl/nsci_ifs.sv
rtl/nal_unit_start_code_indexer_core.sv
sim/nal_unit_tracker.sv
sim/nal_unit_start_code_indexer_core_tb.sv
